>>> hw/rtl/ssbr_pkg.sv
// Shared types and constants for the supersample box resolve block.
// Sample and pixel payload structs, channel sum type, reciprocal table.
// No dependencies.
package ssbr_pkg;

  localparam int NUM_CHAN    = 4;
  localparam int CHAN_W      = 8;
  localparam int SUM_W       = 12;
  localparam int FACTOR_W    = 3;
  localparam int OUT_WIDTH_W = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int PIXEL_X_W   = 10;
  localparam int ROW_W       = 12;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam logic [CFG_INDEX_W-1:0] REG_FACTOR    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_WIDTH = 2'd1;

  localparam logic [FACTOR_W-1:0]    FACTOR_RESET    = 3'd1;
  localparam logic [OUT_WIDTH_W-1:0] OUT_WIDTH_RESET = 11'd640;

  typedef struct packed {
    logic              frame_start;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
    logic [CHAN_W-1:0] alpha_in;
  } sample_t;

  typedef struct packed {
    logic [CHAN_W-1:0]    red_out;
    logic [CHAN_W-1:0]    green_out;
    logic [CHAN_W-1:0]    blue_out;
    logic [CHAN_W-1:0]    alpha_out;
    logic [PIXEL_X_W-1:0] pixel_x;
    logic [ROW_W-1:0]     pixel_y;
  } pixel_t;

  // channel order: 3 red, 2 green, 1 blue, 0 alpha
  typedef logic [NUM_CHAN-1:0][SUM_W-1:0]  sums_t;
  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] chans_t;

  typedef struct packed {
    logic first;
    logic last;
  } box_pos_t;

  // ceil(2^20 / (f*f)); exact floor division for 12-bit sums and f up to 7
  function automatic logic [RECIP_W-1:0] recip_for(input logic [FACTOR_W-1:0] f);
    logic [RECIP_W-1:0] m;
    case (f)
      3'd2:    m = 21'd262144;
      3'd3:    m = 21'd116509;
      3'd4:    m = 21'd65536;
      3'd5:    m = 21'd41944;
      3'd6:    m = 21'd29128;
      3'd7:    m = 21'd21400;
      default: m = 21'd1048576;
    endcase
    return m;
  endfunction

endpackage

>>> hw/rtl/ssbr_row_ram.sv
// Row memory of per-column channel sums, one write and one registered read port.
// Depends on ssbr_pkg.
module ssbr_row_ram
  import ssbr_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  sums_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output sums_t         rd_data
);

  sums_t mem [DEPTH];

  // read returns the old contents when both ports hit the same entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/ssbr_pos_ctrl.sv
// Position counters: place in the box, output column and output row.
// Depends on ssbr_pkg.
module ssbr_pos_ctrl
  import ssbr_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_FACTOR = 4,
  parameter int AW         = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                frame_start,
  input  logic [FACTOR_W-1:0] factor,
  input  logic [OUT_WIDTH_W-1:0] out_width,
  output logic [AW-1:0]       col,
  output logic [ROW_W-1:0]    row,
  output box_pos_t            pos
);

  localparam int SW  = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
  localparam int FCW = 4;
  localparam int WCW = AW + 1;
  localparam int OWW = 13;

  logic [SW-1:0]    sub_column, sub_column_next;
  logic [SW-1:0]    sub_row, sub_row_next;
  logic [AW-1:0]    out_column, out_column_next;
  logic [ROW_W-1:0] out_row, out_row_next;

  logic [FCW-1:0] f_eff;
  logic [WCW-1:0] w_eff;
  logic [OWW-1:0] ow_ext;
  logic [SW-1:0]  sc, sr;
  logic           col_wrap, row_wrap, line_wrap;

  always_comb begin
    if (factor == '0) begin
      f_eff = FCW'(1);
    end else if (FCW'(factor) > FCW'(MAX_FACTOR)) begin
      f_eff = FCW'(MAX_FACTOR);
    end else begin
      f_eff = FCW'(factor);
    end
    ow_ext = OWW'(out_width);
    if (ow_ext == '0) begin
      w_eff = WCW'(1);
    end else if (ow_ext > OWW'(MAX_WIDTH)) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = WCW'(ow_ext);
    end
  end

  // frame_start clears the counters before this sample is placed
  always_comb begin
    sc  = frame_start ? '0 : sub_column;
    sr  = frame_start ? '0 : sub_row;
    col = frame_start ? '0 : out_column;
    row = frame_start ? '0 : out_row;

    col_wrap  = (FCW'(sc) + FCW'(1)) >= f_eff;
    row_wrap  = (FCW'(sr) + FCW'(1)) >= f_eff;
    line_wrap = (WCW'(col) + WCW'(1)) >= w_eff;

    pos.first = (sc == '0) && (sr == '0);
    pos.last  = col_wrap && row_wrap;

    sub_column_next = sc;
    sub_row_next    = sr;
    out_column_next = col;
    out_row_next    = row;
    if (col_wrap) begin
      sub_column_next = '0;
      if (line_wrap) begin
        out_column_next = '0;
        if (row_wrap) begin
          sub_row_next = '0;
          out_row_next = row + ROW_W'(1);
        end else begin
          sub_row_next = sr + SW'(1);
        end
      end else begin
        out_column_next = col + AW'(1);
      end
    end else begin
      sub_column_next = sc + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub_column <= '0;
      sub_row    <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (accept) begin
      sub_column <= sub_column_next;
      sub_row    <= sub_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
    end
  end

endmodule

>>> hw/rtl/ssbr_scale.sv
// Divide box sums by factor squared: reciprocal multiply, then shift and saturate
// into the output register. Depends on ssbr_pkg.
module ssbr_scale
  import ssbr_pkg::*;
#(
  parameter int AW = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sums_t               sums,
  input  logic [AW-1:0]       col,
  input  logic [ROW_W-1:0]    row,
  input  logic [FACTOR_W-1:0] f_eff,
  output logic                out_valid,
  input  logic                out_stall,
  output pixel_t              out_data
);

  logic                                s2_valid;
  logic [NUM_CHAN-1:0][PROD_W-1:0]     s2_prod;
  logic [AW-1:0]                       s2_col;
  logic [ROW_W-1:0]                    s2_row;
  logic                                s2_adv;
  logic [RECIP_W-1:0]                  recip;
  chans_t                              quot;
  logic [PROD_W-RECIP_SHIFT-1:0]       q_full;

  assign recip    = recip_for(f_eff);
  assign s2_adv   = !out_valid || !out_stall;
  assign in_ready = !s2_valid || s2_adv;

  always_comb begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      q_full   = s2_prod[ch][PROD_W-1:RECIP_SHIFT];
      quot[ch] = (q_full > (PROD_W-RECIP_SHIFT)'(255)) ? 8'hFF : q_full[CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s2_valid <= in_valid;
      end
      if (s2_adv) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        s2_prod[ch] <= PROD_W'(sums[ch]) * PROD_W'(recip);
      end
      s2_col <= col;
      s2_row <= row;
    end
    if (s2_adv && s2_valid) begin
      out_data.red_out   <= quot[3];
      out_data.green_out <= quot[2];
      out_data.blue_out  <= quot[1];
      out_data.alpha_out <= quot[0];
      out_data.pixel_x   <= PIXEL_X_W'(s2_col);
      out_data.pixel_y   <= s2_row;
    end
  end

endmodule

>>> hw/rtl/supersample_box_resolve.sv
// Top level of the supersample box resolve: config registers, accumulate stage
// with row-memory bypass. Depends on ssbr_pkg, ssbr_pos_ctrl, ssbr_row_ram, ssbr_scale.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+-----------------------------
//   sample   | sample_valid / sample_stall  | sample (sample_t)
//   pixel    | pixel_valid  / pixel_stall   | pixel  (pixel_t)
//   cfg      | cfg_valid    / cfg_ready     | cfg_index, cfg_data
//
// One sample per cycle sustained while pixel does not stall; the row memory
// read-modify-write is the loop, closed by a one-entry bypass of the write made on the
// read's edge. A box's last sample passes s1, s2 and the output register to pixel.
// Reset clears counters and valids; row memory is not cleared, the first
// sample of each box overwrites its entry. A stall on pixel backs up to sample.
module supersample_box_resolve
  import ssbr_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_FACTOR = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  sample_t                sample,
  output logic                   pixel_valid,
  input  logic                   pixel_stall,
  output pixel_t                 pixel,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [FACTOR_W-1:0]    factor;
  logic [OUT_WIDTH_W-1:0] out_width;
  logic [FACTOR_W-1:0]    f_eff;

  logic             accept;
  logic [AW-1:0]    cur_col;
  logic [ROW_W-1:0] cur_row;
  box_pos_t         cur_pos;

  logic             s1_valid;
  chans_t           s1_sample;
  logic [AW-1:0]    s1_col;
  logic [ROW_W-1:0] s1_row;
  box_pos_t         s1_pos;
  logic             s1_byp;
  sums_t            s1_byp_sum;
  logic             s1_adv;
  logic             wr_en;
  sums_t            rd_sums;
  sums_t            prev;
  sums_t            sum;
  logic             scale_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      factor    <= FACTOR_RESET;
      out_width <= OUT_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FACTOR:    factor    <= cfg_data[FACTOR_W-1:0];
        REG_OUT_WIDTH: out_width <= cfg_data[OUT_WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped factor for the divider; the 3-bit register never exceeds 7
  always_comb begin
    if (factor == '0) begin
      f_eff = FACTOR_W'(1);
    end else if (4'(factor) > 4'(MAX_FACTOR)) begin
      f_eff = FACTOR_W'(MAX_FACTOR);
    end else begin
      f_eff = factor;
    end
  end

  assign s1_adv       = !s1_pos.last || scale_ready;
  assign sample_stall = s1_valid && !s1_adv;
  assign accept       = sample_valid && !sample_stall;
  assign wr_en        = s1_valid && s1_adv;

  ssbr_pos_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR),
    .AW         (AW)
  ) u_pos (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .frame_start (sample.frame_start),
    .factor      (factor),
    .out_width   (out_width),
    .col         (cur_col),
    .row         (cur_row),
    .pos         (cur_pos)
  );

  ssbr_row_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_col),
    .wr_data (sum),
    .rd_en   (accept),
    .rd_addr (cur_col),
    .rd_data (rd_sums)
  );

  // the entry being written on the read's edge is taken from the bypass
  always_comb begin
    prev = s1_byp ? s1_byp_sum : rd_sums;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      sum[ch] = (s1_pos.first ? '0 : prev[ch]) + SUM_W'(s1_sample[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample  <= {sample.red_in, sample.green_in, sample.blue_in, sample.alpha_in};
      s1_col     <= cur_col;
      s1_row     <= cur_row;
      s1_pos     <= cur_pos;
      s1_byp     <= wr_en && (s1_col == cur_col);
      s1_byp_sum <= sum;
    end
  end

  ssbr_scale #(
    .AW (AW)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid && s1_pos.last),
    .in_ready  (scale_ready),
    .sums      (sum),
    .col       (s1_col),
    .row       (s1_row),
    .f_eff     (f_eff),
    .out_valid (pixel_valid),
    .out_stall (pixel_stall),
    .out_data  (pixel)
  );

endmodule
